FILE: design/assert_macros.svh
// Assertion macros shared by the stack design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: design/swrk_pkg.sv
// Package with types, codes and defaults for the keyed stack
`default_nettype none

package swrk_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int NAME_BYTES_DEF = 8;
	localparam int NAME_W         = 64;
	localparam int AGE_W          = 8;
	localparam int FILL_W         = 7;

	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_LIST   = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [AGE_W-1:0]  age;
	} entry_t;

endpackage

`default_nettype wire

FILE: design/swrk_mem.sv
// Record memory: one write port, one read port with registered read data
`default_nettype none

module swrk_mem
	import swrk_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output      entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/stack_with_remove_by_key.sv
// Top level of the bounded record stack with remove by key
//
//  channel | valid        | stall        | payload
//  item    | item_valid   | item_stall   | action, name_key, age
//  result  | result_valid | result_stall | out_name, out_age, status, last, fill
//
// Push writes memory and loads the output register directly; its word sits in the output register the next cycle.
// Pop does one memory read, then the output register loads.
// Remove does one memory read per record, with compacting write-back behind it.
// List gives one word per cycle while the output register drains, one read ahead.
// Reset clears the record count and control; memory contents are left as they are.
`default_nettype none

module stack_with_remove_by_key
	import swrk_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire logic [1:0]        action,
	input  wire logic [NAME_W-1:0] name_key,
	input  wire logic [AGE_W-1:0]  age,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      logic [NAME_W-1:0] out_name,
	output      logic [AGE_W-1:0]  out_age,
	output      logic [1:0]        status,
	output      logic              last,
	output      logic [FILL_W-1:0] fill
);

`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_RM   = 2'd2;
	localparam logic [1:0] S_LIST = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     rd_idx_q, rd_idx_d;
	logic [CW-1:0]     w_q, w_d;
	logic [NAME_W-1:0] key_q, key_d;
	logic              found_q, found_d;
	logic              pend_s1, pend_d;

	logic              out_valid_q;
	logic [NAME_W-1:0] out_name_q;
	logic [AGE_W-1:0]  out_age_q;
	logic [1:0]        status_q;
	logic              last_q;
	logic [FILL_W-1:0] fill_q;

	logic              out_load;
	entry_t            out_ent;
	logic [1:0]        out_st;
	logic              out_last;
	logic [CW-1:0]     out_cnt;

	logic              we, re;
	logic [AW-1:0]     waddr, raddr;
	entry_t            wdata, rdata;

	logic              acc, out_free, match;
	logic [NAME_W-1:0] key_m;

	swrk_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign item_stall = (state_q != S_IDLE) || (out_valid_q && result_stall);
	assign acc        = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign key_m      = name_key & NAME_MASK;
	assign match      = (rdata.name == key_q);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rd_idx_d = rd_idx_q;
		w_d      = w_q;
		key_d    = key_q;
		found_d  = found_q;
		pend_d   = pend_s1;
		we       = 1'b0;
		waddr    = AW'(cnt_q);
		wdata    = '{name: key_m, age: age};
		re       = 1'b0;
		raddr    = '0;
		out_load = 1'b0;
		out_ent  = '0;
		out_st   = ST_DONE;
		out_last = 1'b1;
		out_cnt  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (action)
						ACT_PUSH: begin
							out_load = 1'b1;
							if (cnt_q >= CW'(DEPTH)) begin
								out_st = ST_FULL;
							end else begin
								we      = 1'b1;
								cnt_d   = cnt_q + 1'b1;
								out_cnt = cnt_q + 1'b1;
							end
						end
						ACT_POP: begin
							if (cnt_q == '0) begin
								out_load = 1'b1;
								out_st   = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = AW'(cnt_q - 1'b1);
								cnt_d   = cnt_q - 1'b1;
								state_d = S_POP;
							end
						end
						ACT_REMOVE: begin
							key_d = key_m;
							if (cnt_q == '0) begin
								out_load = 1'b1;
								out_st   = ST_NOTFOUND;
							end else begin
								re       = 1'b1;
								raddr    = '0;
								rd_idx_d = CW'(1);
								w_d      = '0;
								pend_d   = 1'b1;
								found_d  = 1'b0;
								state_d  = S_RM;
							end
						end
						ACT_LIST: begin
							if (cnt_q == '0) begin
								out_load = 1'b1;
								out_st   = ST_EMPTY;
							end else begin
								re       = 1'b1;
								raddr    = AW'(cnt_q - 1'b1);
								rd_idx_d = cnt_q - 1'b1;
								state_d  = S_LIST;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_POP: begin
				out_load = 1'b1;
				out_ent  = rdata;
				state_d  = S_IDLE;
			end
			S_RM: begin
				if (pend_s1) begin
					if (match) begin
						found_d = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = AW'(w_q);
						wdata = rdata;
						w_d   = w_q + 1'b1;
					end
					if (rd_idx_q < cnt_q) begin
						re       = 1'b1;
						raddr    = AW'(rd_idx_q);
						rd_idx_d = rd_idx_q + 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end else begin
					cnt_d    = w_q;
					out_load = 1'b1;
					out_st   = found_q ? ST_DONE : ST_NOTFOUND;
					out_cnt  = w_q;
					state_d  = S_IDLE;
				end
			end
			S_LIST: begin
				if (out_free) begin
					out_load = 1'b1;
					out_ent  = rdata;
					out_last = (rd_idx_q == '0);
					if (rd_idx_q == '0) begin
						state_d = S_IDLE;
					end else begin
						re       = 1'b1;
						raddr    = AW'(rd_idx_q - 1'b1);
						rd_idx_d = rd_idx_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_idx_d;
		w_q      <= w_d;
		key_q    <= key_d;
		found_q  <= found_d;
		if (out_load) begin
			out_name_q <= out_ent.name;
			out_age_q  <= out_ent.age;
			status_q   <= out_st;
			last_q     <= out_last;
			fill_q     <= FILL_W'(out_cnt);
		end
	end

	assign result_valid = out_valid_q;
	assign out_name     = out_name_q;
	assign out_age      = out_age_q;
	assign status       = status_q;
	assign last         = last_q;
	assign fill         = fill_q;

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(DEPTH))
	`ASSERT_NEVER(a_out_overrun, clk, arst_n, out_load && out_valid_q && result_stall)
	`ASSERT_CLK(a_rm_order, clk, arst_n, (state_q == S_RM && pend_s1) |-> (w_q < rd_idx_q))
	`ASSERT_CLK(a_full_fill, clk, arst_n, (result_valid && status == ST_FULL) |-> (fill == FILL_W'(DEPTH)))

endmodule

`default_nettype wire

FILE: verif/stack_with_remove_by_key_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard package: record stack predictor and store of expected result words
package stack_with_remove_by_key_sb_pkg;
	import swrk_pkg::*;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [AGE_W-1:0]  age;
		logic [1:0]        status;
		logic              last;
		logic [FILL_W-1:0] fill;
	} result_word_t;

	class keyed_stack_scoreboard;
		logic [NAME_W-1:0] names [DEPTH_DEF];
		logic [AGE_W-1:0]  ages [DEPTH_DEF];
		int unsigned       held;
		result_word_t      expected_words [$];
		int unsigned       failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		function void add_expected(logic [NAME_W-1:0] nm, logic [AGE_W-1:0] ag,
				logic [1:0] st, logic lst);
			result_word_t w;
			w.name = nm;
			w.age = ag;
			w.status = st;
			w.last = lst;
			w.fill = FILL_W'(held);
			expected_words.push_back(w);
		endfunction

		function void note_word(logic [1:0] act, logic [NAME_W-1:0] key_in,
				logic [AGE_W-1:0] ag);
			logic [NAME_W-1:0] key;
			int unsigned       keep;
			bit                hit;
			int                i;
			key = key_in & ({NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES_DEF));
			case (act)
				ACT_PUSH: begin
					if (held >= DEPTH_DEF) begin
						add_expected('0, '0, ST_FULL, 1'b1);
					end else begin
						names[held] = key;
						ages[held] = ag;
						held++;
						add_expected('0, '0, ST_DONE, 1'b1);
					end
				end
				ACT_POP: begin
					if (held == 0) begin
						add_expected('0, '0, ST_EMPTY, 1'b1);
					end else begin
						held--;
						add_expected(names[held], ages[held], ST_DONE, 1'b1);
					end
				end
				ACT_REMOVE: begin
					keep = 0;
					hit = 1'b0;
					for (i = 0; i < int'(held); i++) begin
						if (names[i] == key) begin
							hit = 1'b1;
						end else begin
							names[keep] = names[i];
							ages[keep] = ages[i];
							keep++;
						end
					end
					held = keep;
					add_expected('0, '0, hit ? ST_DONE : ST_NOTFOUND, 1'b1);
				end
				ACT_LIST: begin
					if (held == 0) begin
						add_expected('0, '0, ST_EMPTY, 1'b1);
					end else begin
						for (i = int'(held) - 1; i >= 0; i--) begin
							add_expected(names[i], ages[i], ST_DONE, i == 0);
						end
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(logic [NAME_W-1:0] nm, logic [AGE_W-1:0] ag,
				logic [1:0] st, logic lst, logic [FILL_W-1:0] fl);
			result_word_t w;
			if (expected_words.size() == 0) begin
				$error({"unexpected result word: out_name %h out_age %0d",
					" status %0d last %0d fill %0d"}, nm, ag, st, lst, fl);
				failures++;
				return;
			end
			w = expected_words.pop_front();
			if (nm !== w.name) begin
				$error("out_name expected %h actual %h", w.name, nm);
				failures++;
			end
			if (ag !== w.age) begin
				$error("out_age expected %0d actual %0d", w.age, ag);
				failures++;
			end
			if (st !== w.status) begin
				$error("status expected %0d actual %0d", w.status, st);
				failures++;
			end
			if (lst !== w.last) begin
				$error("last expected %0d actual %0d", w.last, lst);
				failures++;
			end
			if (fl !== w.fill) begin
				$error("fill expected %0d actual %0d", w.fill, fl);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction
	endclass

endpackage

FILE: verif/stack_with_remove_by_key_test.sv
`timescale 1ns / 100ps
// Top-level testbench of the record stack with remove by key
module stack_with_remove_by_key_test;
	import swrk_pkg::*;
	import stack_with_remove_by_key_sb_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [1:0]        action = ACT_PUSH;
	logic [NAME_W-1:0] name_key = '0;
	logic [AGE_W-1:0]  age = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [NAME_W-1:0] out_name;
	logic [AGE_W-1:0]  out_age;
	logic [1:0]        status;
	logic              last;
	logic [FILL_W-1:0] fill;

	int idle_pct = 0;
	int stall_pct = 0;
	logic [NAME_W-1:0] key_pool [4] = '{"OAK", "PINE", "ELM", "ASH"};

	keyed_stack_scoreboard sb = new();

	stack_with_remove_by_key DUT (.*);

	always #2 clk = ~clk;

	always @(negedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_word(out_name, out_age, status, last, fill);
			if (item_valid && !item_stall)
				sb.note_word(action, name_key, age);
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [NAME_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return {NAME_W{1'b1}};
			2: return '0;
			default: return key_pool[$urandom_range(3)];
		endcase
	endfunction

	function automatic logic [AGE_W-1:0] pick_age();
		case ($urandom_range(9))
			0: return '0;
			1: return {AGE_W{1'b1}};
			default: return AGE_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_item(logic [1:0] act, logic [NAME_W-1:0] key, logic [AGE_W-1:0] ag);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		name_key <= key;
		age <= ag;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	task automatic send_random(int push_pct);
		int r;
		logic [1:0] act;
		r = $urandom_range(99);
		if (r < push_pct)
			act = ACT_PUSH;
		else if (r < push_pct + (100 - push_pct) * 4 / 10)
			act = ACT_POP;
		else if (r < push_pct + (100 - push_pct) * 7 / 10)
			act = ACT_REMOVE;
		else
			act = ACT_LIST;
		send_item(act, pick_key(), pick_age());
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int phase;
		int i;
		int bias [4];
		bias = '{50, 35, 62, 45};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(ACT_LIST, '0, '0);
		send_item(ACT_POP, '0, '0);
		send_item(ACT_REMOVE, key_pool[3], '0);
		send_item(ACT_PUSH, {NAME_W{1'b1}}, {AGE_W{1'b1}});
		send_item(ACT_PUSH, '0, '0);
		send_item(ACT_PUSH, key_pool[0], 8'd7);
		send_item(ACT_PUSH, key_pool[1], 8'd9);
		send_item(ACT_PUSH, key_pool[0], 8'd11);
		send_item(ACT_LIST, '0, '0);
		send_item(ACT_REMOVE, key_pool[0], '0);
		send_item(ACT_REMOVE, key_pool[2], '0);
		send_item(ACT_LIST, '0, '0);
		send_item(ACT_POP, '0, '0);
		send_item(ACT_POP, '0, '0);
		send_item(ACT_POP, '0, '0);
		send_item(ACT_POP, '0, '0);
		send_item(ACT_PUSH, key_pool[2], 8'd42);
		send_item(ACT_REMOVE, key_pool[2], '0);
		send_item(ACT_LIST, '0, '0);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 60 : (phase == 3) ? 36 : 0;
			stall_pct = (phase == 2) ? 60 : (phase == 3) ? 36 : 0;
			if (phase == 1) begin
				for (i = 0; i < DEPTH_DEF + 2; i++)
					send_item(ACT_PUSH, pick_key(), pick_age());
				send_item(ACT_LIST, '0, '0);
				send_item(ACT_REMOVE, key_pool[$urandom_range(3)], '0);
			end
			for (i = 0; i < 80; i++)
				send_random(bias[phase]);
			drain();
		end

		repeat (DEPTH_DEF + 8) @(negedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
